// ----- hdl/fpc8_pkg.sv -----
// Shared constants, status codes and the bytewise CRC-8 function for the frame checker.
package fpc8_pkg;

  localparam int unsigned FRAME_LEN_DEF = 16;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [7:0]       HDR_BYTE   = 8'hFF;
  localparam logic [7:0]       TRL_BYTE   = 8'hEE;
  localparam logic [7:0]       CRC_POLY   = 8'h1D;
  localparam logic [7:0]       CRC_INIT   = 8'hFF;
  localparam logic [7:0]       CRC_XOROUT = 8'hFF;
  localparam logic [POS_W-1:0] POS_MAX    = 7'd127;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LENGTH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FRAMING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CRC     = 2'd3;

  typedef logic [7:0] byte_t;

  function automatic byte_t crc8_byte(input byte_t crc, input byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/framed_packet_crc8_checker_top.sv -----
// Frame checker: length, header, trailer and CRC-8 over the payload, one word per cycle.
// Accepted words enter the input register; result words are registered at the output.
// Throughput: one word per cycle unless the output stalls; byte CRC is combinational.
// While a result word is stalled, the input register takes one more word, then stalls.
// Reset (rst_n low, synchronous) empties the pipeline, clears the burst state
// and sets the CRC check enable to 1.
module framed_packet_crc8_checker_top #(
  parameter int unsigned FRAME_LEN = fpc8_pkg::FRAME_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_crc_check_enable,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fpc8_pkg::byte_t               in_data_byte,
  input  logic                          in_end_of_read,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_payload_valid,
  output logic [fpc8_pkg::IDX_W-1:0]    out_payload_index,
  output fpc8_pkg::byte_t               out_payload_byte,
  output logic                          out_frame_done,
  output logic [fpc8_pkg::STATUS_W-1:0] out_frame_status
);
  import fpc8_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST_PAY = POS_W'(FRAME_LEN - 3);
  localparam logic [POS_W-1:0] POS_CRC      = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] POS_TRL      = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] POS_LEN      = POS_W'(FRAME_LEN);

  logic                crc_en_r;
  logic                s1_valid_r;
  byte_t               s1_byte_r;
  logic                s1_last_r;
  logic                s1_ready;
  logic                s2_ready;
  logic                s2_load;

  logic [POS_W-1:0]    pos_r, pos_nxt, pos_inc;
  byte_t               crc_r, crc_nxt;
  logic                hdr_ok_r, hdr_ok_nxt;
  logic                trl_ok_r, trl_ok_nxt;
  logic                crc_ok_r, crc_ok_nxt;

  logic                pv_nxt;
  logic [IDX_W-1:0]    pidx_nxt;
  byte_t               pbyte_nxt;
  logic [STATUS_W-1:0] status_nxt;

  logic                out_valid_r;
  logic                pv_r;
  logic [IDX_W-1:0]    pidx_r;
  byte_t               pbyte_r;
  logic                done_r;
  logic [STATUS_W-1:0] status_r;

  assign cfg_ready = 1'b1;
  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign s2_load   = s1_valid_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      crc_en_r <= cfg_crc_check_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_end_of_read;
    end
  end

  always_comb begin
    crc_nxt    = crc_r;
    hdr_ok_nxt = hdr_ok_r;
    trl_ok_nxt = trl_ok_r;
    crc_ok_nxt = crc_ok_r;
    pv_nxt     = 1'b0;
    pidx_nxt   = '0;
    pbyte_nxt  = '0;
    status_nxt = ST_OK;

    if (pos_r == '0) begin
      hdr_ok_nxt = (s1_byte_r == HDR_BYTE);
    end else if (pos_r <= POS_LAST_PAY) begin
      crc_nxt   = crc8_byte(crc_r, s1_byte_r);
      pv_nxt    = 1'b1;
      pidx_nxt  = IDX_W'(pos_r - 7'd1);
      pbyte_nxt = s1_byte_r;
    end else if (pos_r == POS_CRC) begin
      crc_ok_nxt = (s1_byte_r == (crc_r ^ CRC_XOROUT));
    end else if (pos_r == POS_TRL) begin
      trl_ok_nxt = (s1_byte_r == TRL_BYTE);
    end

    pos_inc = (pos_r < POS_MAX) ? pos_r + 7'd1 : pos_r;
    pos_nxt = pos_inc;

    if (s1_last_r) begin
      if (pos_inc != POS_LEN) begin
        status_nxt = ST_LENGTH;
      end else if (!(hdr_ok_nxt && trl_ok_nxt)) begin
        status_nxt = ST_FRAMING;
      end else if (crc_en_r && !crc_ok_nxt) begin
        status_nxt = ST_CRC;
      end
      pos_nxt    = '0;
      crc_nxt    = CRC_INIT;
      hdr_ok_nxt = 1'b0;
      trl_ok_nxt = 1'b0;
      crc_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      hdr_ok_r <= 1'b0;
      trl_ok_r <= 1'b0;
      crc_ok_r <= 1'b0;
    end else if (s2_load) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      trl_ok_r <= trl_ok_nxt;
      crc_ok_r <= crc_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      pv_r     <= pv_nxt;
      pidx_r   <= pidx_nxt;
      pbyte_r  <= pbyte_nxt;
      done_r   <= s1_last_r;
      status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = pv_r;
  assign out_payload_index = pidx_r;
  assign out_payload_byte  = pbyte_r;
  assign out_frame_done    = done_r;
  assign out_frame_status  = status_r;

endmodule

// ----- hdl/fpc8_checker.sv -----
// Port-level assertions for the frame checker and the bind that attaches them.
module fpc8_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_payload_valid,
  input logic [fpc8_pkg::IDX_W-1:0]    out_payload_index,
  input fpc8_pkg::byte_t               out_payload_byte,
  input logic                          out_frame_done,
  input logic [fpc8_pkg::STATUS_W-1:0] out_frame_status
);
  import fpc8_pkg::*;

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_status) && $stable(out_frame_done))
    else $error("stalled result word changed");

  // A status other than accepted appears only on the word that ends a burst.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_frame_status == ST_OK)
    else $error("status reported without end of burst");

  // Payload index and byte are zero outside the payload region.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_index == '0 && out_payload_byte == '0)
    else $error("payload fields set outside payload");

  // A new result word is presented only after an input word was taken.
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without matching input word");

endmodule

bind framed_packet_crc8_checker_top fpc8_checker u_fpc8_checker (.*);

// ----- dv/framed_packet_crc8_checker_tb.sv -----
// Testbench for the framed packet CRC-8 checker: randomized frames, idling and a scoreboard.
`timescale 1ns / 100ps

module tb;
  import fpc8_pkg::*;

  localparam int unsigned FRAME_LEN   = FRAME_LEN_DEF;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned ITEM_TARGET = 1100;

  typedef enum int {
    FR_GOOD, FR_BAD_CRC, FR_BAD_HDR, FR_BAD_TRL, FR_SHORT, FR_LONG, FR_NOISE
  } frame_kind_e;

  typedef struct {
    logic                payload_valid;
    logic [IDX_W-1:0]    payload_index;
    byte_t               payload_byte;
    logic                frame_done;
    logic [STATUS_W-1:0] frame_status;
  } frame_result_t;

  class crc8_frame_scoreboard;
    int unsigned     frame_len;
    bit              enable;
    logic [POS_W-1:0] position;
    byte_t           crc_acc;
    bit              header_ok;
    bit              trailer_ok;
    bit              crc_ok;
    frame_result_t   expected_words[$];
    int              errors;

    function new(int unsigned flen);
      frame_len = flen;
      enable    = 1'b1;
      errors    = 0;
      clear_burst();
    endfunction

    function void clear_burst();
      position   = '0;
      crc_acc    = CRC_INIT;
      header_ok  = 1'b0;
      trailer_ok = 1'b0;
      crc_ok     = 1'b0;
    endfunction

    // Bit-serial CRC-8, data shifted in MSB first.
    function byte_t crc_update(byte_t c, byte_t d);
      byte_t r;
      bit    fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[7] ^ d[i];
        r  = {r[6:0], 1'b0};
        if (fb) begin
          r = r ^ CRC_POLY;
        end
      end
      return r;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_word(byte_t b, logic last);
      frame_result_t    r;
      logic [POS_W-1:0] p;
      r = '{1'b0, '0, '0, 1'b0, ST_OK};
      p = position;
      if (p == 0) begin
        header_ok = (b == HDR_BYTE);
      end else if (p <= frame_len - 3) begin
        crc_acc         = crc_update(crc_acc, b);
        r.payload_valid = 1'b1;
        r.payload_index = IDX_W'(p - 1);
        r.payload_byte  = b;
      end else if (p == frame_len - 2) begin
        crc_ok = (b == (crc_acc ^ CRC_XOROUT));
      end else if (p == frame_len - 1) begin
        trailer_ok = (b == TRL_BYTE);
      end
      if (position < POS_MAX) begin
        position = position + 1'b1;
      end
      if (last) begin
        r.frame_done = 1'b1;
        if (position != frame_len) begin
          r.frame_status = ST_LENGTH;
        end else if (!(header_ok && trailer_ok)) begin
          r.frame_status = ST_FRAMING;
        end else if (enable && !crc_ok) begin
          r.frame_status = ST_CRC;
        end else begin
          r.frame_status = ST_OK;
        end
        clear_burst();
      end
      expected_words.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_word(frame_result_t got);
      frame_result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, got done=%0b",
                 $time, got.frame_done);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
      compare("payload_index", 8'(want.payload_index), 8'(got.payload_index));
      compare("payload_byte", want.payload_byte, got.payload_byte);
      compare("frame_done", 8'(want.frame_done), 8'(got.frame_done));
      compare("frame_status", 8'(want.frame_status), 8'(got.frame_status));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_crc_check_enable = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  byte_t               in_data_byte = '0;
  logic                in_end_of_read = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_payload_valid;
  logic [IDX_W-1:0]    out_payload_index;
  byte_t               out_payload_byte;
  logic                out_frame_done;
  logic [STATUS_W-1:0] out_frame_status;

  crc8_frame_scoreboard sb;
  byte_t                data_q[$];
  bit                   no_idle = 1'b0;
  int                   item_count = 0;
  int                   stall_left = 0;
  int                   idle_cycles = 0;

  framed_packet_crc8_checker_top #(.FRAME_LEN(FRAME_LEN)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_crc_check_enable (cfg_crc_check_enable),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_end_of_read       (in_end_of_read),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_payload_valid    (out_payload_valid),
    .out_payload_index    (out_payload_index),
    .out_payload_byte     (out_payload_byte),
    .out_frame_done       (out_frame_done),
    .out_frame_status     (out_frame_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_t rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return TRL_BYTE;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 52) return FR_GOOD;
    if (r < 62) return FR_BAD_CRC;
    if (r < 69) return FR_BAD_HDR;
    if (r < 76) return FR_BAD_TRL;
    if (r < 85) return FR_SHORT;
    if (r < 94) return FR_LONG;
    return FR_NOISE;
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !no_idle && ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    frame_result_t got;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        sb.note_word(in_data_byte, in_end_of_read);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.payload_valid = out_payload_valid;
        got.payload_index = out_payload_index;
        got.payload_byte  = out_payload_byte;
        got.frame_done    = out_frame_done;
        got.frame_status  = out_frame_status;
        sb.check_word(got);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** framed_packet_crc8_checker_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(input byte_t b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_end_of_read <= last;
    do @(posedge clk); while (in_stall);
    item_count++;
  endtask

  task automatic send_burst(input bit noisy);
    logic last;
    for (int i = 0; i < data_q.size(); i++) begin
      last = (i == data_q.size() - 1) || (noisy && $urandom_range(0, 7) == 0);
      send_word(data_q[i], last);
    end
  endtask

  task automatic build_frame(input frame_kind_e kind);
    byte_t crc;
    byte_t b;
    int    n;
    data_q.delete();
    data_q.push_back(HDR_BYTE);
    crc = CRC_INIT;
    for (int i = 1; i <= FRAME_LEN - 3; i++) begin
      b = rand_byte();
      data_q.push_back(b);
      crc = sb.crc_update(crc, b);
    end
    data_q.push_back(crc ^ CRC_XOROUT);
    data_q.push_back(TRL_BYTE);
    case (kind)
      FR_BAD_CRC: begin
        data_q[FRAME_LEN-2] = data_q[FRAME_LEN-2] ^ byte_t'($urandom_range(1, 255));
      end
      FR_BAD_HDR: begin
        data_q[0] = byte_t'($urandom_range(0, 254));
        if ($urandom_range(0, 3) == 0) begin
          data_q[FRAME_LEN-1] = ~TRL_BYTE;
        end
      end
      FR_BAD_TRL: begin
        b = byte_t'($urandom_range(0, 254));
        data_q[FRAME_LEN-1] = (b >= TRL_BYTE) ? b + 1'b1 : b;
      end
      FR_SHORT: begin
        n = $urandom_range(1, FRAME_LEN - 1);
        while (data_q.size() > n) data_q.pop_back();
      end
      FR_LONG: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(POS_MAX - FRAME_LEN, POS_MAX + 20 - FRAME_LEN)
                                        : $urandom_range(1, 8);
        repeat (n) data_q.push_back(rand_byte());
      end
      FR_NOISE: begin
        data_q.delete();
        n = $urandom_range(1, 40);
        repeat (n) data_q.push_back(rand_byte());
      end
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_crc_enable(input logic v);
    cfg_valid            <= 1'b1;
    cfg_crc_check_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.enable = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    frame_kind_e kind;
    int          phase;
    sb = new(FRAME_LEN);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A good frame whose payload walks the byte extremes, then a one-word burst.
    data_q.delete();
    data_q.push_back(HDR_BYTE);
    begin
      byte_t crc;
      crc = CRC_INIT;
      for (int i = 1; i <= FRAME_LEN - 3; i++) begin
        data_q.push_back((i % 2) ? 8'h00 : 8'hFF);
        crc = sb.crc_update(crc, data_q[i]);
      end
      data_q.push_back(crc ^ CRC_XOROUT);
      data_q.push_back(TRL_BYTE);
    end
    send_burst(1'b0);
    send_word(8'h00, 1'b1);

    phase = 0;
    while (item_count < ITEM_TARGET) begin
      wait_idle();
      write_crc_enable((phase % 2) != 0);
      no_idle = (phase % 3 == 2);
      repeat (12) begin
        kind = pick_kind();
        build_frame(kind);
        send_burst(kind == FR_NOISE);
      end
      phase++;
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** framed_packet_crc8_checker_top: PASSED **");
    end else begin
      $display("** framed_packet_crc8_checker_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- framed_packet_crc8_checker_top.f -----
hdl/fpc8_pkg.sv
hdl/framed_packet_crc8_checker_top.sv
hdl/fpc8_checker.sv
dv/framed_packet_crc8_checker_tb.sv
